FILE: rtl/pru_pkg.sv
// Package for the pixel replicate upscaler: field widths, register indexes,
// item codes and small helper functions.
// No dependencies.
package pru_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned DEF_LINE_DEPTH = 1024;
    localparam int unsigned DEF_SCALE_MAX  = 16;

    // Fixed widths of the configuration fields and the pixel channels.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned SCALE_W    = 5;
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned ROWS_W     = 11;
    localparam int unsigned SRC_ROW_W  = 10;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned ROWS_MAX   = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;

    // Item codes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic       row_last;
        logic [1:0] pad_bytes;
        logic       frame_last;
    } t_flags;

    // Zero maps to one, anything above the limit maps to the limit.
    function automatic logic [CFG_DATA_W-1:0] clamp_cfg(
        input logic [CFG_DATA_W-1:0] v,
        input int unsigned           hi
    );
        logic [CFG_DATA_W-1:0] r;
        if (v == '0) begin
            r = CFG_DATA_W'(1);
        end else if (32'(v) > hi) begin
            r = CFG_DATA_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Row padding to a 4-byte boundary for 3 bytes per pixel.
    // (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4.
    function automatic logic [1:0] pad_of(
        input logic [1:0] w,
        input logic [1:0] s
    );
        logic [3:0] p;
        p = {2'b00, w} * {2'b00, s};
        return p[1:0];
    endfunction

endpackage

FILE: rtl/pixel_replicate_upscaler_unit.sv
// Pixel replicate upscaler, top level: line store memory, counters and
// output stage. Depends on pru_pkg.
//
// Nearest-neighbour integer upscaler for 24-bit RGB. Load transfers (mode 0)
// write one source pixel each into the on-chip line store; once line_width
// pixels are stored the unit switches to output, and each fetch transfer
// (mode 1) returns one output pixel. Every stored pixel repeats scale_factor
// times along a row and every row repeats scale_factor times, after which the
// unit waits for the next source row. A load while a row is being output and
// a fetch while a row is still being loaded are dropped without a result.
// The unit takes one item per clock cycle, loads and fetches alike, set by the
// single access per cycle of the line store, unless a stalled output backs up
// into the read stage. A fetch result passes the store read register, then the
// output register; a further fetch can be taken while a result waits. The line
// store needs no clearing after reset. The user must write configuration on
// the always-ready cfg channel only while no item is in flight; not enforced.
module pixel_replicate_upscaler_unit
    import pru_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH,
    parameter int unsigned SCALE_MAX  = DEF_SCALE_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input item channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [CHAN_W-1:0]     i_red,
    input  logic [CHAN_W-1:0]     i_green,
    input  logic [CHAN_W-1:0]     i_blue,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic                  o_row_last,
    output logic [1:0]            o_pad_bytes,
    output logic                  o_frame_last
);

    localparam int unsigned COL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned REP_W = (SCALE_MAX > 1) ? $clog2(SCALE_MAX) : 1;

    // Configuration, held in clamped form.
    logic [SCALE_W-1:0]   r_scale;
    logic [WIDTH_W-1:0]   r_width;
    logic [ROWS_W-1:0]    r_rows;

    // Sequencing state.
    logic [COL_W-1:0]     r_load_col, n_load_col;
    logic [COL_W-1:0]     r_out_col,  n_out_col;
    logic [REP_W-1:0]     r_horiz,    n_horiz;
    logic [REP_W-1:0]     r_vert,     n_vert;
    logic [SRC_ROW_W-1:0] r_src_row,  n_src_row;
    logic                 r_row_ready, n_row_ready;

    // Line store and its read register.
    t_pixel               mem_line [LINE_DEPTH];
    t_pixel               r_rd_data;

    // Pipeline: read stage flags, then output register.
    logic                 r_s1_valid;
    t_flags               r_s1_flags;
    t_flags               n_flags;
    logic                 r_out_valid;
    t_pixel               r_out_pix;
    t_flags               r_out_flags;

    logic                 in_xfer;
    logic                 load_ok;
    logic                 fetch_ok;
    logic                 s1_move;
    logic                 horiz_end;
    logic                 col_end_out;
    logic                 col_end_load;
    logic                 vert_end;
    logic                 rows_end;

    // Configuration writes, clamped on the way in.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= WIDTH_W'(1);
            r_rows  <= ROWS_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCALE: r_scale <= SCALE_W'(clamp_cfg(
                               {{(CFG_DATA_W-SCALE_W){1'b0}}, i_cfg_data[SCALE_W-1:0]},
                               SCALE_MAX));
                REG_WIDTH: r_width <= WIDTH_W'(clamp_cfg(i_cfg_data, LINE_DEPTH));
                REG_ROWS:  r_rows  <= ROWS_W'(clamp_cfg(i_cfg_data, ROWS_MAX));
                default:   ;
            endcase
        end
    end

    // Handshake and item decode.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign load_ok    = in_xfer && (i_mode == MODE_LOAD)  && !r_row_ready;
    assign fetch_ok   = in_xfer && (i_mode == MODE_FETCH) && r_row_ready;

    // End-of-run tests; a counter past a smaller limit also ends its run.
    assign horiz_end    = (32'(r_horiz) + 32'd1) >= 32'(r_scale);
    assign vert_end     = (32'(r_vert) + 32'd1) >= 32'(r_scale);
    assign col_end_out  = (32'(r_out_col) + 32'd1) >= 32'(r_width);
    assign col_end_load = (32'(r_load_col) + 32'd1) >= 32'(r_width);
    assign rows_end     = (32'(r_src_row) + 32'd1) >= 32'(r_rows);

    // Next-state logic for the counters and the result flags.
    always_comb begin
        n_load_col  = r_load_col;
        n_out_col   = r_out_col;
        n_horiz     = r_horiz;
        n_vert      = r_vert;
        n_src_row   = r_src_row;
        n_row_ready = r_row_ready;
        n_flags     = '0;
        if (load_ok) begin
            if (col_end_load) begin
                n_load_col  = '0;
                n_out_col   = '0;
                n_horiz     = '0;
                n_vert      = '0;
                n_row_ready = 1'b1;
            end else begin
                n_load_col = r_load_col + COL_W'(1);
            end
        end else if (fetch_ok) begin
            if (horiz_end) begin
                n_horiz = '0;
                if (col_end_out) begin
                    n_flags.row_last  = 1'b1;
                    n_flags.pad_bytes = pad_of(r_width[1:0], r_scale[1:0]);
                    n_out_col         = '0;
                    if (vert_end) begin
                        n_vert      = '0;
                        n_row_ready = 1'b0;
                        n_load_col  = '0;
                        if (rows_end) begin
                            n_flags.frame_last = 1'b1;
                            n_src_row          = '0;
                        end else begin
                            n_src_row = r_src_row + SRC_ROW_W'(1);
                        end
                    end else begin
                        n_vert = r_vert + REP_W'(1);
                    end
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end else begin
                n_horiz = r_horiz + REP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col  <= '0;
            r_out_col   <= '0;
            r_horiz     <= '0;
            r_vert      <= '0;
            r_src_row   <= '0;
            r_row_ready <= 1'b0;
        end else begin
            r_load_col  <= n_load_col;
            r_out_col   <= n_out_col;
            r_horiz     <= n_horiz;
            r_vert      <= n_vert;
            r_src_row   <= n_src_row;
            r_row_ready <= n_row_ready;
        end
    end

    // Line store: one write or one read per cycle, read data registered.
    // Loads and fetches never share a cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            mem_line[r_load_col] <= t_pixel'{red: i_red, green: i_green, blue: i_blue};
        end
        if (fetch_ok) begin
            r_rd_data <= mem_line[r_out_col];
        end
    end

    // Read stage valid and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fetch_ok) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_ok) begin
            r_s1_flags <= n_flags;
        end
    end

    // Output register; holds while the result transfer is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pix   <= r_rd_data;
            r_out_flags <= r_s1_flags;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_pix.red;
    assign o_out_green  = r_out_pix.green;
    assign o_out_blue   = r_out_pix.blue;
    assign o_row_last   = r_out_flags.row_last;
    assign o_pad_bytes  = r_out_flags.pad_bytes;
    assign o_frame_last = r_out_flags.frame_last;

endmodule

FILE: rtl/pru_checker.sv
// Port-level checks for the pixel replicate upscaler, bound to the top level.
// Depends on pru_pkg and pixel_replicate_upscaler_unit.
module pru_checker
    import pru_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [CHAN_W-1:0]     o_out_red,
    input logic [CHAN_W-1:0]     o_out_green,
    input logic [CHAN_W-1:0]     o_out_blue,
    input logic                  o_row_last,
    input logic [1:0]            o_pad_bytes,
    input logic                  o_frame_last
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_red) &&
        $stable(o_out_green) && $stable(o_out_blue) && $stable(o_row_last) &&
        $stable(o_pad_bytes) && $stable(o_frame_last))
        else $error("result changed while stalled");

    // Padding is only reported at the end of an output row.
    a_pad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_row_last |-> o_pad_bytes == 2'd0)
        else $error("pad bytes without row end");

    // The last pixel of a frame is also the last pixel of its row.
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_row_last)
        else $error("frame end without row end");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pixel_replicate_upscaler_unit pru_checker u_pru_checker (.*);
